// File: design/positional_list_engine_core_macros.svh
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ple_pkg.sv
// Package: types, codes and defaults of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   localparam logic [FUNC_W-1:0] FUNC_ADD_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

endpackage
`default_nettype wire

// File: design/positional_list_engine_core.sv
// Top level: bounded positional list with registered request and result stages.
`timescale 1ns / 1ps
`default_nettype none
// Holds an ordered list of up to CAPACITY signed 32-bit values in a row of
// registers. A request beat is taken whenever start is high; busy never rises,
// so one request can be issued every cycle. Each request gives exactly one
// result beat, marked by rsp_valid for one cycle: the request register takes
// the request, and the result register and the cells load from it in the
// cycle after. The receiver cannot stall, so the result must be captured in the
// cycle that rsp_valid is high. Every cell shifts or updates in parallel
// in the same cycle; a request always sees the list as left by the request
// before it. The list is not cleared at reset beyond its count.
module positional_list_engine_core #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [ple_pkg::FUNC_W-1:0]           req_func,
   input  wire  [ple_pkg::POS_W-1:0]            req_position,
   input  wire  signed [ple_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   output logic signed [ple_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic [ple_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ple_pkg::LEN_W-1:0]            rsp_length,
   output logic                                 rsp_empty_flag
);

`include "positional_list_engine_core_macros.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

   // request stage
   logic             req_valid_ff, req_valid_in;
   ple_pkg::req_type req_ff, req_in;

   // list state
   logic signed [ple_pkg::VALUE_W-1:0] entries_ff [CAPACITY];
   logic signed [ple_pkg::VALUE_W-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0]                   count_ff, count_in;

   // result stage
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [ple_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ple_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [ple_pkg::LEN_W-1:0]           rsp_length_ff, rsp_length_in;
   logic                                rsp_empty_ff, rsp_empty_in;

   logic                                full;
   logic                                in_range;
   logic [IDX_W-1:0]                    idx;
   logic signed [ple_pkg::VALUE_W-1:0]  rd_value;
   logic                                do_front, do_back, do_write, do_remove;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign req_in       = '{func: req_func, position: req_position, value: req_value};

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign in_range = (CMP_W'(req_ff.position) < CMP_W'(count_ff)) &&
                     (CMP_W'(req_ff.position) < CMP_W'(CAPACITY));
   assign idx      = IDX_W'(req_ff.position);
   assign rd_value = entries_ff[idx];

   always_comb begin
      do_front      = 1'b0;
      do_back       = 1'b0;
      do_write      = 1'b0;
      do_remove     = 1'b0;
      count_in      = count_ff;
      rsp_status_in = ple_pkg::STATUS_OK;
      rsp_value_in  = '0;
      if (req_valid_ff) begin
         case (req_ff.func)
            ple_pkg::FUNC_ADD_FRONT, ple_pkg::FUNC_ADD_BACK: begin
               if (full) begin
                  rsp_status_in = ple_pkg::STATUS_FULL;
               end else begin
                  do_front = (req_ff.func == ple_pkg::FUNC_ADD_FRONT);
                  do_back  = (req_ff.func == ple_pkg::FUNC_ADD_BACK);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ple_pkg::FUNC_READ, ple_pkg::FUNC_WRITE, ple_pkg::FUNC_REMOVE: begin
               if (!in_range) begin
                  rsp_status_in = ple_pkg::STATUS_RANGE;
               end else begin
                  rsp_value_in = rd_value;
                  do_write     = (req_ff.func == ple_pkg::FUNC_WRITE);
                  if (req_ff.func == ple_pkg::FUNC_REMOVE) begin
                     do_remove = 1'b1;
                     count_in  = count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               // undefined codes leave the list alone
            end
         endcase
      end
   end

   assign rsp_valid_in  = req_valid_ff;
   assign rsp_length_in = ple_pkg::LEN_W'(count_in);
   assign rsp_empty_in  = (count_in == '0);

   // one cell per list slot, all updated in the same cycle
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(g);
      localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(g);
      logic signed [ple_pkg::VALUE_W-1:0] front_src;
      logic signed [ple_pkg::VALUE_W-1:0] remove_src;

      if (g == 0) begin : g_head
         assign front_src = req_ff.value;
      end else begin : g_body
         assign front_src = entries_ff[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign remove_src = entries_ff[g];
      end else begin : g_inner
         assign remove_src = entries_ff[g+1];
      end

      always_comb begin
         entries_in[g] = entries_ff[g];
         if (do_front) begin
            entries_in[g] = front_src;
         end else if (do_back && (CELL_CNT == count_ff)) begin
            entries_in[g] = req_ff.value;
         end else if (do_write && (CELL_IDX == idx)) begin
            entries_in[g] = req_ff.value;
         end else if (do_remove && (CELL_IDX >= idx)) begin
            entries_in[g] = remove_src;
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[g] <= entries_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_length       = rsp_length_ff;
   assign rsp_empty_flag   = rsp_empty_ff;

   `PLE_ASSERT_NEXT(a_beat_gives_result, clock, reset, req_valid_ff, rsp_valid,
      "request beat did not produce a result beat")
   `PLE_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "entry count above capacity")
   `PLE_ASSERT_NEXT(a_count_holds_when_idle, clock, reset, !req_valid_ff, $stable(count_ff),
      "entry count moved without a request")
   `PLE_ASSERT_SAME(a_full_length, clock, reset,
      rsp_valid && (rsp_status == ple_pkg::STATUS_FULL),
      (rsp_length == ple_pkg::LEN_W'(CAPACITY)) && (rsp_result_value == '0),
      "full status reported with a list that is not full")

endmodule
`default_nettype wire
